// ===== hdl/vasfs_pkg.sv =====
package vasfs_pkg;

   localparam int POS_BITS         = 24;
   localparam int DIR_BITS         = 16;
   localparam int REG_BITS         = 7;
   localparam int PH_BITS          = 6;
   localparam int UV_BITS          = 16;
   localparam int DIFF_BITS        = POS_BITS + 1;
   localparam int PROD_BITS        = DIR_BITS + DIFF_BITS;
   localparam int SUM_BITS         = PROD_BITS + 2;
   localparam int CORDIC_BITS      = SUM_BITS + 4;
   localparam int ANGLE_BITS_DEF   = 16;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_ENTRIES     = 24;
   localparam int REM_BITS         = REG_BITS;
   localparam int DIVW_PH          = PH_BITS;
   localparam int DIVW_UV          = PH_BITS + UV_BITS;

   localparam logic [REG_BITS-1:0] RESET_NUM_PHASES = 7'd8;
   localparam logic [REG_BITS-1:0] RESET_PER_ROW    = 7'd8;
   localparam logic [REG_BITS-1:0] RESET_PER_COL    = 7'd1;
   localparam logic [REG_BITS-1:0] REG_MAX          = 7'd64;

   typedef enum logic [1:0] {
      CSR_NUM_PHASES = 2'd0,
      CSR_PER_ROW    = 2'd1,
      CSR_PER_COL    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [DIR_BITS-1:0] fwd_x;
      logic signed [DIR_BITS-1:0] fwd_y;
      logic signed [DIR_BITS-1:0] fwd_z;
      logic signed [DIR_BITS-1:0] rgt_x;
      logic signed [DIR_BITS-1:0] rgt_y;
      logic signed [DIR_BITS-1:0] rgt_z;
      logic signed [POS_BITS-1:0] obj_x;
      logic signed [POS_BITS-1:0] obj_y;
      logic signed [POS_BITS-1:0] obj_z;
      logic signed [POS_BITS-1:0] cam_x;
      logic signed [POS_BITS-1:0] cam_y;
      logic signed [POS_BITS-1:0] cam_z;
   } req_type;

   typedef struct packed {
      logic [PH_BITS-1:0] phase;
      logic [PH_BITS-1:0] sheet_column;
      logic [PH_BITS-1:0] sheet_row;
      logic [UV_BITS-1:0] uv_x;
      logic [UV_BITS-1:0] uv_y;
   } rsp_type;

   localparam logic [31:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10680862, 32'd5340245, 32'd2670675, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   function automatic logic [31:0] atan_step(int step, int abits);
      logic [32:0] t;
      t = {1'b0, ATAN_TURN32[step]} + (33'd1 << (31 - abits));
      return 32'(t >> (32 - abits));
   endfunction

   function automatic logic [REG_BITS-1:0] clamp_reg(logic [REG_BITS-1:0] v);
      logic [REG_BITS-1:0] r;
      r = v;
      if (v == '0) r = 7'd1;
      else if (v > REG_MAX) r = REG_MAX;
      return r;
   endfunction

endpackage

// ===== hdl/vasfs_cordic_cell.sv =====
module vasfs_cordic_cell #(
   parameter int CW   = 47,
   parameter int AB   = 16,
   parameter int STEP = 0
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [CW-1:0] src_x,
   input  logic signed [CW-1:0] src_y,
   input  logic [AB-1:0]        src_z,
   input  logic                 src_tag,
   output logic signed [CW-1:0] dst_x,
   output logic signed [CW-1:0] dst_y,
   output logic [AB-1:0]        dst_z,
   output logic                 dst_tag
);
   import vasfs_pkg::*;

   localparam logic [AB-1:0] ANG = AB'(atan_step(STEP, AB));

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, xs, ys;
   logic [AB-1:0]        z_ff, z_in;
   logic                 tag_ff;

   always_comb begin
      xs = src_x >>> STEP;
      ys = src_y >>> STEP;
      if (!src_y[CW-1]) begin
         x_in = src_x + ys;
         y_in = src_y - xs;
         z_in = src_z + ANG;
      end else begin
         x_in = src_x - ys;
         y_in = src_y + xs;
         z_in = src_z - ANG;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         tag_ff <= src_tag;
      end
   end

   assign dst_x   = x_ff;
   assign dst_y   = y_ff;
   assign dst_z   = z_ff;
   assign dst_tag = tag_ff;

endmodule

// ===== hdl/vasfs_div_cell.sv =====
module vasfs_div_cell #(
   parameter int W  = 6,
   parameter int TW = 6
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic [vasfs_pkg::REM_BITS-1:0] src_rem,
   input  logic [W-1:0]                   src_work,
   input  logic [vasfs_pkg::REG_BITS-1:0] divisor,
   input  logic [TW-1:0]                  src_tag,
   output logic [vasfs_pkg::REM_BITS-1:0] dst_rem,
   output logic [W-1:0]                   dst_work,
   output logic [TW-1:0]                  dst_tag
);
   import vasfs_pkg::*;

   logic [REM_BITS:0]   t, dv;
   logic                ge;
   logic [REM_BITS-1:0] rem_ff, rem_in;
   logic [W-1:0]        work_ff, work_in;
   logic [TW-1:0]       tag_ff;

   always_comb begin
      t       = {src_rem, src_work[W-1]};
      dv      = {1'b0, divisor};
      ge      = t >= dv;
      rem_in  = ge ? REM_BITS'(t - dv) : t[REM_BITS-1:0];
      work_in = {src_work[W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         work_ff <= work_in;
         tag_ff  <= src_tag;
      end
   end

   assign dst_rem  = rem_ff;
   assign dst_work = work_ff;
   assign dst_tag  = tag_ff;

endmodule

// ===== hdl/view_angle_sprite_frame_select_unit.sv =====
// throughput: one item per cycle unless stalled, from fully pipelined CORDIC and divider cells
// any cycle the output holds an untaken result the whole chain stalls
// synchronous active-high reset clears the valid chain and loads the register defaults
// (num_phases 8, per_row 8, per_col 1); payload registers are not reset
module view_angle_sprite_frame_select_unit #(
   parameter int ANGLE_BITS   = vasfs_pkg::ANGLE_BITS_DEF,
   parameter int CORDIC_STEPS = vasfs_pkg::CORDIC_STEPS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  vasfs_pkg::req_type             req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output vasfs_pkg::rsp_type             rsp_data,
   input  logic                           csr_we,
   input  logic [1:0]                     csr_index,
   input  logic [vasfs_pkg::REG_BITS-1:0] csr_wdata
);
   import vasfs_pkg::*;

   localparam int CS  = CORDIC_STEPS;
   localparam int AB  = ANGLE_BITS;
   localparam int CW  = CORDIC_BITS;
   localparam int MW  = AB + REG_BITS;
   localparam int LAT = CS + 35;

   logic [REG_BITS-1:0] num_ff, prow_ff, pcol_ff, n_eff, pr_eff, pc_eff;
   logic [LAT-1:0]      vld_ff;
   logic                en, stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff  <= RESET_NUM_PHASES;
         prow_ff <= RESET_PER_ROW;
         pcol_ff <= RESET_PER_COL;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_NUM_PHASES: num_ff  <= csr_wdata;
            CSR_PER_ROW:    prow_ff <= csr_wdata;
            CSR_PER_COL:    pcol_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign n_eff  = clamp_reg(num_ff);
   assign pr_eff = clamp_reg(prow_ff);
   assign pc_eff = clamp_reg(pcol_ff);

   assign stall     = vld_ff[LAT-1] && !rsp_ready;
   assign en        = !stall;
   assign req_ready = en;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // difference and direction capture, per-axis products and forward/right sums
   logic signed [DIR_BITS-1:0]  fwd_ff [3];
   logic signed [DIR_BITS-1:0]  rgt_ff [3];
   logic signed [DIFF_BITS-1:0] d_ff   [3];
   logic signed [PROD_BITS-1:0] pf_ff  [3];
   logic signed [PROD_BITS-1:0] pr_ff  [3];
   logic signed [SUM_BITS-1:0]  f_ff, r_ff;
   logic                        zero_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         fwd_ff[0] <= req_data.fwd_x;
         fwd_ff[1] <= req_data.fwd_y;
         fwd_ff[2] <= req_data.fwd_z;
         rgt_ff[0] <= req_data.rgt_x;
         rgt_ff[1] <= req_data.rgt_y;
         rgt_ff[2] <= req_data.rgt_z;
         d_ff[0]   <= DIFF_BITS'(req_data.obj_x) - DIFF_BITS'(req_data.cam_x);
         d_ff[1]   <= DIFF_BITS'(req_data.obj_y) - DIFF_BITS'(req_data.cam_y);
         d_ff[2]   <= DIFF_BITS'(req_data.obj_z) - DIFF_BITS'(req_data.cam_z);
         for (int k = 0; k < 3; k++) begin
            pf_ff[k] <= fwd_ff[k] * d_ff[k];
            pr_ff[k] <= rgt_ff[k] * d_ff[k];
         end
         f_ff <= SUM_BITS'(pf_ff[0]) + SUM_BITS'(pf_ff[1]) + SUM_BITS'(pf_ff[2]);
         r_ff <= SUM_BITS'(pr_ff[0]) + SUM_BITS'(pr_ff[1]) + SUM_BITS'(pr_ff[2]);
      end
   end

   // half-turn prerotation into the right half plane
   logic signed [CW-1:0] cx [CS+1];
   logic signed [CW-1:0] cy [CS+1];
   logic [AB-1:0]        cz [CS+1];
   logic                 ct [CS+1];
   logic signed [CW-1:0] x0_ff, y0_ff;
   logic [AB-1:0]        z0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff <= (f_ff == '0) && (r_ff == '0);
         if (f_ff[SUM_BITS-1]) begin
            x0_ff <= -CW'(f_ff);
            y0_ff <= -CW'(r_ff);
            z0_ff <= AB'(1) << (AB - 1);
         end else begin
            x0_ff <= CW'(f_ff);
            y0_ff <= CW'(r_ff);
            z0_ff <= '0;
         end
      end
   end

   assign cx[0] = x0_ff;
   assign cy[0] = y0_ff;
   assign cz[0] = z0_ff;
   assign ct[0] = zero_ff;

   for (genvar i = 0; i < CS; i++) begin : g_cordic
      vasfs_cordic_cell #(.CW(CW), .AB(AB), .STEP(i)) u_cell (
         .clock   (clock),
         .en      (en),
         .src_x   (cx[i]),
         .src_y   (cy[i]),
         .src_z   (cz[i]),
         .src_tag (ct[i]),
         .dst_x   (cx[i+1]),
         .dst_y   (cy[i+1]),
         .dst_z   (cz[i+1]),
         .dst_tag (ct[i+1])
      );
   end

   // sector rounding
   logic [MW-1:0]       prod_ff;
   logic                zm_ff;
   logic [PH_BITS-1:0]  ph_ff;
   logic [REG_BITS-1:0] q;

   assign q = prod_ff[MW-1:AB];

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= MW'(cz[CS]) * MW'(n_eff) + (MW'(1) << (AB - 1));
         zm_ff   <= ct[CS];
         if (zm_ff || q == n_eff) ph_ff <= '0;
         else                     ph_ff <= q[PH_BITS-1:0];
      end
   end

   // phase divided by per_row
   logic [REM_BITS-1:0] ar [DIVW_PH+1];
   logic [DIVW_PH-1:0]  aw [DIVW_PH+1];
   logic [PH_BITS-1:0]  at [DIVW_PH+1];

   assign ar[0] = '0;
   assign aw[0] = ph_ff;
   assign at[0] = ph_ff;

   for (genvar i = 0; i < DIVW_PH; i++) begin : g_div_ph
      vasfs_div_cell #(.W(DIVW_PH), .TW(PH_BITS)) u_cell (
         .clock    (clock),
         .en       (en),
         .src_rem  (ar[i]),
         .src_work (aw[i]),
         .divisor  (pr_eff),
         .src_tag  (at[i]),
         .dst_rem  (ar[i+1]),
         .dst_work (aw[i+1]),
         .dst_tag  (at[i+1])
      );
   end

   // uv lanes
   logic [REM_BITS-1:0]  xr [DIVW_UV+1];
   logic [DIVW_UV-1:0]   xw [DIVW_UV+1];
   logic [2*PH_BITS-1:0] xt [DIVW_UV+1];
   logic [REM_BITS-1:0]  yr [DIVW_UV+1];
   logic [DIVW_UV-1:0]   yw [DIVW_UV+1];
   logic [PH_BITS-1:0]   yt [DIVW_UV+1];

   assign xr[0] = '0;
   assign xw[0] = {ar[DIVW_PH][PH_BITS-1:0], {UV_BITS{1'b0}}};
   assign xt[0] = {at[DIVW_PH], ar[DIVW_PH][PH_BITS-1:0]};
   assign yr[0] = '0;
   assign yw[0] = {aw[DIVW_PH], {UV_BITS{1'b0}}};
   assign yt[0] = aw[DIVW_PH];

   for (genvar i = 0; i < DIVW_UV; i++) begin : g_div_uv
      vasfs_div_cell #(.W(DIVW_UV), .TW(2 * PH_BITS)) u_cell_x (
         .clock    (clock),
         .en       (en),
         .src_rem  (xr[i]),
         .src_work (xw[i]),
         .divisor  (pr_eff),
         .src_tag  (xt[i]),
         .dst_rem  (xr[i+1]),
         .dst_work (xw[i+1]),
         .dst_tag  (xt[i+1])
      );
      vasfs_div_cell #(.W(DIVW_UV), .TW(PH_BITS)) u_cell_y (
         .clock    (clock),
         .en       (en),
         .src_rem  (yr[i]),
         .src_work (yw[i]),
         .divisor  (pc_eff),
         .src_tag  (yt[i]),
         .dst_rem  (yr[i+1]),
         .dst_work (yw[i+1]),
         .dst_tag  (yt[i+1])
      );
   end

   rsp_type out_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff.phase        <= xt[DIVW_UV][2*PH_BITS-1:PH_BITS];
         out_ff.sheet_column <= xt[DIVW_UV][PH_BITS-1:0];
         out_ff.sheet_row    <= yt[DIVW_UV];
         out_ff.uv_x         <= xw[DIVW_UV][UV_BITS-1:0];
         out_ff.uv_y         <= (|yw[DIVW_UV][DIVW_UV-1:UV_BITS]) ? {UV_BITS{1'b1}}
                                                                  : yw[DIVW_UV][UV_BITS-1:0];
      end
   end

   assign rsp_data = out_ff;

   a_col_le_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.sheet_column <= rsp_data.phase)
      else $error("sheet column above phase");

   a_row0_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sheet_row == '0 |-> rsp_data.sheet_column == rsp_data.phase)
      else $error("row zero with column not equal to phase");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule
